### hw/rtl/assert_macros.svh
// Assertion macros used by the dense layer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/dlsf_pkg.sv
// Package: sizes, codes and the sigmoid constant table
package dlsf_pkg;
    localparam int VISIBLE_MAX = 1024;
    localparam int HIDDEN_MAX  = 64;
    localparam int VIS_W       = $clog2(VISIBLE_MAX);
    localparam int HID_W       = $clog2(HIDDEN_MAX);
    localparam int WADDR_W     = VIS_W + HID_W;
    localparam int ACC_W       = 48;

    localparam logic [1:0] KIND_WEIGHT  = 2'd0;
    localparam logic [1:0] KIND_BIAS    = 2'd1;
    localparam logic [1:0] KIND_VISIBLE = 2'd2;

    localparam logic [0:0] CFG_HIDDEN_COUNT  = 1'b0;
    localparam logic [0:0] CFG_VISIBLE_COUNT = 1'b1;

    // exp(-2^(k-12)) in Q.16
    function automatic logic [15:0] expc(input logic [3:0] k);
        logic [15:0] r;
        begin
            case (k)
                4'd0:    r = 16'd65520;
                4'd1:    r = 16'd65504;
                4'd2:    r = 16'd65472;
                4'd3:    r = 16'd65408;
                4'd4:    r = 16'd65280;
                4'd5:    r = 16'd65026;
                4'd6:    r = 16'd64520;
                4'd7:    r = 16'd63520;
                4'd8:    r = 16'd61565;
                4'd9:    r = 16'd57835;
                4'd10:   r = 16'd51039;
                4'd11:   r = 16'd39750;
                4'd12:   r = 16'd24109;
                4'd13:   r = 16'd8869;
                4'd14:   r = 16'd1200;
                4'd15:   r = 16'd22;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction
endpackage

### hw/rtl/dlsf_ram.sv
// Generic single-port RAM with registered read
module dlsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hw/rtl/dlsf_sigmoid.sv
// Iterative sigmoid: exp product over 16 bit steps then restoring divide
module dlsf_sigmoid (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [dlsf_pkg::ACC_W-1:0] z,
    output logic                        busy,
    output logic                        done,
    output logic [15:0]                 result
);
    import dlsf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXP, S_DIV, S_FIN} state_t;

    state_t       state_reg;
    logic [16:0]  a_reg;
    logic         neg_reg;
    logic [16:0]  e_reg;
    logic [4:0]   k_reg;
    logic [17:0]  d_reg;
    logic [33:0]  num_reg;
    logic [18:0]  rem_reg;
    logic [17:0]  q_reg;
    logic [5:0]   bit_reg;

    // Argument: floor shift by 15 and saturate to +-32768
    logic signed [32:0] x_sh;
    logic signed [32:0] x_sat;
    logic [16:0]        a_in;
    always_comb
    begin
        x_sh = z[ACC_W-1:15];
        if (x_sh > 33'sd32768)
            x_sat = 33'sd32768;
        else if (x_sh < -33'sd32768)
            x_sat = -33'sd32768;
        else
            x_sat = x_sh;
        a_in = x_sat[32] ? 17'(-x_sat) : 17'(x_sat);
    end

    // One exp multiply step
    logic [33:0] e_prod;
    assign e_prod = e_reg * expc(k_reg[3:0]) + 34'd32768;

    // One restoring division step
    logic [18:0] rem_sh;
    logic        ge;
    assign rem_sh = {rem_reg[17:0], num_reg[bit_reg]};
    assign ge     = rem_sh >= {1'b0, d_reg};

    logic [17:0] q_fin;
    assign q_fin = neg_reg ? 18'd65536 - q_reg : q_reg;

    assign busy = (state_reg != S_IDLE);

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a_in;
                        neg_reg   <= x_sat[32];
                        e_reg     <= 17'd65536;
                        k_reg     <= 5'd0;
                        state_reg <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    if (a_reg[k_reg[3:0]])
                        e_reg <= 17'(e_prod >> 16);
                    k_reg <= k_reg + 5'd1;
                    if (k_reg == 5'd15)
                        state_reg <= S_DIV;
                    if (k_reg == 5'd15)
                    begin
                        d_reg   <= 18'd65536;
                        num_reg <= 34'd0;
                        rem_reg <= 19'd0;
                        q_reg   <= 18'd0;
                        bit_reg <= 6'd33;
                    end
                end
                S_DIV:
                begin
                    // First cycle of divide loads operands
                    if (bit_reg == 6'd33 && d_reg == 18'd65536 && num_reg == 34'd0)
                    begin
                        d_reg   <= 18'd65536 + 18'(e_reg);
                        num_reg <= 34'h1_0000_0000 + 34'((18'd65536 + 18'(e_reg)) >> 1);
                        bit_reg <= 6'd33;
                        rem_reg <= 19'd0;
                    end
                    else
                    begin
                        rem_reg <= ge ? rem_sh - {1'b0, d_reg} : rem_sh;
                        q_reg   <= {q_reg[16:0], ge};
                        bit_reg <= bit_reg - 6'd1;
                        if (bit_reg == 6'd0)
                            state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    result    <= (q_fin > 18'd65535) ? 16'hFFFF : q_fin[15:0];
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/dense_layer_sigmoid_forward_unit.sv
// Dense layer with sigmoid: weight/bias storage, shared MAC and output sequencer
// A weight or bias write is taken in S_IDLE; a visible value in range is swept over all
// HIDDEN_MAX units in the shared MAC, with a read and a write-back per unit.
// On vector end each unit is read, starts the shared sigmoid (16 exp steps, a divide,
// finish), waits on it and is then sent, holding while the output stalls.
// One transaction in flight at a time; reset clears control and accumulator valid bits.
module dense_layer_sigmoid_forward_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [10:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic [dlsf_pkg::VIS_W-1:0]   visible_index,
    input  logic [dlsf_pkg::HID_W-1:0]   hidden_index,
    input  logic signed [15:0]           coefficient,
    input  logic [15:0]                  visible_value,
    input  logic                         vector_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dlsf_pkg::HID_W-1:0]   unit_index,
    output logic [15:0]                  probability,
    output logic                         burst_end
);
    import dlsf_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_MAC_RD, S_MAC, S_OUT_RD, S_OUT_SIG, S_OUT_WAIT, S_OUT_SEND
    } state_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    state_t             state_reg;
    logic [6:0]         hidden_count_reg;
    logic [10:0]        visible_count_reg;
    logic [VIS_W-1:0]   row_reg;
    logic [15:0]        val_reg;
    logic               last_reg;
    logic [HID_W:0]     h_reg;
    logic [HID_W-1:0]   rd_h_reg;
    logic [6:0]         hc_reg;
    logic [HIDDEN_MAX-1:0]   acc_vld_reg;
    logic               sig_start_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidden_count_reg  <= 7'd64;
            visible_count_reg <= 11'd784;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIDDEN_COUNT:  hidden_count_reg  <= cfg_data[6:0];
                CFG_VISIBLE_COUNT: visible_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic in_fire;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Weight and bias memories
    logic               w_we;
    logic [WADDR_W-1:0] w_addr;
    logic [15:0]        w_rdata;
    logic               b_we;
    logic [HID_W-1:0]   b_addr;
    logic [15:0]        b_rdata;

    assign w_we   = in_fire && kind == KIND_WEIGHT;
    assign w_addr = in_fire ? {visible_index, hidden_index}
                            : {row_reg, h_reg[HID_W-1:0]};
    assign b_we   = in_fire && kind == KIND_BIAS;
    assign b_addr = in_fire ? hidden_index : h_reg[HID_W-1:0];

    dlsf_ram #(.WIDTH(16), .DEPTH(VISIBLE_MAX * HIDDEN_MAX)) u_wram (
        .clk(clk), .we(w_we), .addr(w_addr), .wdata(coefficient), .rdata(w_rdata)
    );
    dlsf_ram #(.WIDTH(16), .DEPTH(HIDDEN_MAX)) u_bram (
        .clk(clk), .we(b_we), .addr(b_addr), .wdata(coefficient), .rdata(b_rdata)
    );

    // Accumulator memory: read in S_MAC_RD, the cycle before, write back in the MAC cycle
    logic               a_we;
    logic [HID_W-1:0]   a_addr;
    logic [ACC_W-1:0]   a_rdata;
    assign a_we   = (state_reg == S_MAC);
    assign a_addr = (state_reg == S_MAC) ? rd_h_reg : h_reg[HID_W-1:0];

    // Shared multiply-accumulate with 48-bit saturation
    logic signed [ACC_W-1:0] acc_cur;
    logic signed [32:0]      prod;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    assign acc_cur = acc_vld_reg[rd_h_reg] ? $signed(a_rdata) : '0;
    assign prod    = $signed({1'b0, val_reg}) * $signed(w_rdata);
    assign acc_sum = {acc_cur[ACC_W-1], acc_cur} + (ACC_W+1)'(prod);
    always_comb
    begin
        if (acc_sum > (ACC_W+1)'(ACC_MAX))
            acc_sat = ACC_MAX;
        else if (acc_sum < (ACC_W+1)'(ACC_MIN))
            acc_sat = ACC_MIN;
        else
            acc_sat = acc_sum[ACC_W-1:0];
    end

    dlsf_ram #(.WIDTH(ACC_W), .DEPTH(HIDDEN_MAX)) u_aram (
        .clk(clk), .we(a_we), .addr(a_addr), .wdata(acc_sat), .rdata(a_rdata)
    );

    // Sigmoid argument: accumulator plus bias scaled by 2^15, clamped to 48 bits
    logic signed [ACC_W:0]   z_sum;
    logic signed [ACC_W-1:0] z_val;
    assign z_sum = {acc_cur[ACC_W-1], acc_cur}
                 + {{(ACC_W-30){b_rdata[15]}}, b_rdata, 15'd0};
    always_comb
    begin
        if (z_sum[ACC_W] != z_sum[ACC_W-1])
            z_val = z_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            z_val = z_sum[ACC_W-1:0];
    end

    logic        sig_busy;
    logic        sig_done;
    logic [15:0] sig_result;

    dlsf_sigmoid u_sig (
        .clk(clk), .rst_n(rst_n), .start(sig_start_reg), .z(z_val),
        .busy(sig_busy), .done(sig_done), .result(sig_result)
    );

    logic [10:0] vlim;
    assign vlim = (visible_count_reg < 11'(VISIBLE_MAX)) ? visible_count_reg
                                                         : 11'(VISIBLE_MAX);

    // Sequencer: MAC sweep, then sigmoid per unit with output hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_vld_reg   <= '0;
            out_valid     <= 1'b0;
            sig_start_reg <= 1'b0;
            h_reg         <= '0;
        end
        else
        begin
            sig_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && kind == KIND_VISIBLE)
                    begin
                        row_reg  <= visible_index;
                        val_reg  <= visible_value;
                        last_reg <= vector_end;
                        h_reg    <= '0;
                        if (hidden_count_reg == 7'd0)
                            hc_reg <= 7'd1;
                        else if (hidden_count_reg > 7'(HIDDEN_MAX))
                            hc_reg <= 7'(HIDDEN_MAX);
                        else
                            hc_reg <= hidden_count_reg;
                        if (11'(visible_index) < vlim)
                            state_reg <= S_MAC_RD;
                        else if (vector_end)
                            state_reg <= S_OUT_RD;
                    end
                end
                S_MAC_RD:
                begin
                    // Weight and accumulator reads for h_reg are issued now
                    rd_h_reg  <= h_reg[HID_W-1:0];
                    h_reg     <= h_reg + 1'b1;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    acc_vld_reg[rd_h_reg] <= 1'b1;
                    if (h_reg == (HID_W+1)'(HIDDEN_MAX))
                    begin
                        h_reg     <= '0;
                        state_reg <= last_reg ? S_OUT_RD : S_IDLE;
                    end
                    else
                        state_reg <= S_MAC_RD;
                end
                S_OUT_RD:
                begin
                    rd_h_reg  <= h_reg[HID_W-1:0];
                    state_reg <= S_OUT_SIG;
                end
                S_OUT_SIG:
                begin
                    sig_start_reg <= 1'b1;
                    state_reg     <= S_OUT_WAIT;
                end
                S_OUT_WAIT:
                begin
                    if (sig_done)
                    begin
                        out_valid   <= 1'b1;
                        unit_index  <= rd_h_reg;
                        probability <= sig_result;
                        burst_end   <= (7'(h_reg) + 7'd1 == hc_reg);
                        state_reg   <= S_OUT_SEND;
                    end
                end
                S_OUT_SEND:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        if (burst_end)
                        begin
                            acc_vld_reg <= '0;
                            h_reg       <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            h_reg     <= h_reg + 1'b1;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `CHK_IMPL(a_out_only_send, clk, rst_n, out_valid, state_reg == S_OUT_SEND, "output valid outside send")
    `CHK_IMPL(a_no_accept_busy, clk, rst_n, sig_busy, !in_ready, "input accepted while sigmoid busy")
    `CHK_NEXT(a_start_busy, clk, rst_n, sig_start_reg, sig_busy, "sigmoid did not start")
    `CHK_NEXT(a_burst_clear, clk, rst_n, out_valid && out_ready && burst_end, acc_vld_reg == '0, "accumulators not cleared")
endmodule
